// File: rtl/vta_pkg.sv
// Shared types and constants of the vertex tangent accumulator.
// Depends on nothing; vta_serial, the top level and the checker import it.
`default_nettype none

package vta_pkg;

	localparam int IDX_W        = 8;
	localparam int MAX_VERTICES = 256;
	localparam int FIX_W        = 32;
	localparam int SUM_W        = 40;
	localparam int VTX_W        = 5 * FIX_W;
	localparam int SUMS_W       = 3 * SUM_W;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_TRI  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	typedef struct packed {
		logic [1:0]              command;
		logic [IDX_W-1:0]        vertex_index;
		logic signed [FIX_W-1:0] pos_x;
		logic signed [FIX_W-1:0] pos_y;
		logic signed [FIX_W-1:0] pos_z;
		logic signed [FIX_W-1:0] tex_u;
		logic signed [FIX_W-1:0] tex_v;
		logic [IDX_W-1:0]        corner_a;
		logic [IDX_W-1:0]        corner_b;
		logic [IDX_W-1:0]        corner_c;
	} vta_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]   out_vertex;
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic               zero_length;
	} vta_res_t;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} vta_sreq_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic ovf;
	} vta_sstat_t;

endpackage

`default_nettype wire

// File: rtl/vta_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
`default_nettype none

module vta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/vta_serial.sv
// Shared bit-serial arithmetic unit: unsigned multiply, restoring divide and
// integer square root, one quotient or root bit per cycle. Uses vta_pkg.
`default_nettype none

module vta_serial (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vta_pkg::vta_sreq_t    req,
	input  logic [63:0]           opa,
	input  logic [48:0]           opb,
	output vta_pkg::vta_sstat_t   stat,
	output logic [63:0]           result
);
	import vta_pkg::*;

	logic [1:0]  op_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [5:0]  last_cnt;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [31:0] mc_q;
	logic [63:0] num_q;
	logic [48:0] rem_q;
	logic [48:0] dvs_q;
	logic [40:0] quo_q;
	logic        ovf_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;

	logic [32:0] mul_sum;
	logic [49:0] div_t;
	logic [49:0] div_d;
	logic        div_ge;
	logic [35:0] sq_t;
	logic [35:0] sq_trial;
	logic        sq_ge;

	assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : 33'd0);
	assign div_t    = {rem_q, num_q[63]};
	assign div_d    = {1'b0, dvs_q};
	assign div_ge   = (div_t >= div_d);
	assign sq_t     = {srem_q, num_q[63:62]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = (sq_t >= sq_trial);

	always_comb begin
		case (op_q)
			OP_DIV:  last_cnt = 6'd63;
			default: last_cnt = 6'd31;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			hi_q   <= 32'd0;
			lo_q   <= opb[31:0];
			mc_q   <= opa[31:0];
			num_q  <= opa;
			rem_q  <= 49'd0;
			dvs_q  <= opb;
			quo_q  <= 41'd0;
			ovf_q  <= 1'b0;
			srem_q <= 34'd0;
			root_q <= 32'd0;
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					hi_q <= mul_sum[32:1];
					lo_q <= {mul_sum[0], lo_q[31:1]};
				end
				OP_DIV: begin
					rem_q <= div_ge ? 49'(div_t - div_d) : div_t[48:0];
					num_q <= {num_q[62:0], 1'b0};
					quo_q <= {quo_q[39:0], div_ge};
					// Quotient bits pushed past bit 40 only mean saturation.
					ovf_q <= ovf_q | quo_q[40];
				end
				OP_SQRT: begin
					srem_q <= sq_ge ? 34'(sq_t - sq_trial) : sq_t[33:0];
					root_q <= {root_q[30:0], sq_ge};
					num_q  <= {num_q[61:0], 2'b00};
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (op_q)
			OP_MUL:  result = {hi_q, lo_q};
			OP_DIV:  result = {23'd0, quo_q};
			OP_SQRT: result = {32'd0, root_q};
			default: result = 64'd0;
		endcase
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;

endmodule

`default_nettype wire

// File: rtl/vertex_tangent_accumulator.sv
// Top level of the vertex tangent accumulator. Uses vta_pkg, vta_ram and
// vta_serial.
`default_nettype none

// One command beat is taken at a time. A load is written in the cycle it is
// accepted and the block is ready again in the next cycle. A triangle runs
// eight products and three divisions on the shared bit-serial unit and ends
// after the first two products when the UV determinant is zero; a read runs
// three squares, a square root and three divisions on it and skips them all
// when the sum is zero. A result beat waits in an output register, so new
// commands are taken while it is still stalled; a second read finishing
// before the first result is taken holds until the register frees.
// Vertices must be loaded before a triangle or a read refers to them.
module vertex_tangent_accumulator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  vta_pkg::vta_cmd_t cmd_data,
	output logic              res_valid,
	input  logic              res_stall,
	output vta_pkg::vta_res_t res_data
);
	import vta_pkg::*;

	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_FETCH     = 5'd1;
	localparam logic [4:0] ST_MUL_GO    = 5'd2;
	localparam logic [4:0] ST_MUL_WAIT  = 5'd3;
	localparam logic [4:0] ST_DIV_GO    = 5'd4;
	localparam logic [4:0] ST_DIV_WAIT  = 5'd5;
	localparam logic [4:0] ST_UPD_RD    = 5'd6;
	localparam logic [4:0] ST_UPD_WR    = 5'd7;
	localparam logic [4:0] ST_RD_ADDR   = 5'd8;
	localparam logic [4:0] ST_RD_CAP    = 5'd9;
	localparam logic [4:0] ST_RD_SHIFT  = 5'd10;
	localparam logic [4:0] ST_SQ_GO     = 5'd11;
	localparam logic [4:0] ST_SQ_WAIT   = 5'd12;
	localparam logic [4:0] ST_SQRT_GO   = 5'd13;
	localparam logic [4:0] ST_SQRT_WAIT = 5'd14;
	localparam logic [4:0] ST_Q_GO      = 5'd15;
	localparam logic [4:0] ST_Q_WAIT    = 5'd16;
	localparam logic [4:0] ST_OUT       = 5'd17;

	function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) return d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		return d[31:0];
	endfunction

	function automatic logic [39:0] add_sat(input logic [39:0] a, input logic [39:0] b);
		logic [40:0] d;
		d = {a[39], a} + {b[39], b};
		if (d[40] != d[39]) return d[40] ? 40'h80_0000_0000 : 40'h7f_ffff_ffff;
		return d[39:0];
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] a);
		return a[31] ? (~a + 32'd1) : a;
	endfunction

	logic [4:0]         st_q;
	logic [2:0]         idx_q;
	logic               res_valid_q;
	vta_cmd_t           cmd_q;
	vta_res_t           res_q;
	logic [VTX_W-1:0]   v0_q;
	logic [31:0]        e1_q [3];
	logic [31:0]        e2_q [3];
	logic [31:0]        du1_q;
	logic [31:0]        dv1_q;
	logic [31:0]        du2_q;
	logic [31:0]        dv2_q;
	logic               mneg_q;
	logic               dneg_q;
	logic [47:0]        prod_q;
	logic [47:0]        det_q;
	logic [47:0]        num_q [3];
	logic [39:0]        t_q [3];
	logic [39:0]        mag_q [3];
	logic               sgn_q [3];
	logic [63:0]        ssum_q;
	logic [31:0]        len_q;
	logic [15:0]        rq_q [3];
	logic               zero_q;

	logic               accept;
	logic               out_free;
	logic [IDX_W-1:0]   corner;
	logic [VTX_W-1:0]   vtx_rdata;
	logic               vtx_we;
	logic [SUMS_W-1:0]  sum_rdata;
	logic [SUMS_W-1:0]  sum_wdata;
	logic [SUMS_W-1:0]  sum_upd;
	logic               sum_we;
	logic [IDX_W-1:0]   sum_waddr;
	logic [IDX_W-1:0]   sum_raddr;
	vta_sreq_t          sreq;
	vta_sstat_t         sstat;
	logic [63:0]        opa;
	logic [48:0]        opb;
	logic [63:0]        sres;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        sprod;
	logic [47:0]        prod_s;
	logic [47:0]        diff;
	logic [47:0]        num_k;
	logic [47:0]        num_abs;
	logic [47:0]        det_abs;
	logic [39:0]        mag_k;
	logic [40:0]        quo;
	logic [39:0]        tsat;
	logic [15:0]        qsat;
	logic               big;
	logic [39:0]        rd_x;
	logic [39:0]        rd_y;
	logic [39:0]        rd_z;

	assign accept    = cmd_valid && (st_q == ST_IDLE);
	assign cmd_stall = (st_q != ST_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_comb begin
		case (idx_q[1:0])
			2'd0:    corner = cmd_q.corner_a;
			2'd1:    corner = cmd_q.corner_b;
			default: corner = cmd_q.corner_c;
		endcase
	end

	// Position and UV record: x, y, z, u, v from the low bits up.
	assign vtx_we = accept && (cmd_data.command == CMD_LOAD);

	vta_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
		.clk   (clk),
		.we    (vtx_we),
		.waddr (cmd_data.vertex_index),
		.wdata ({cmd_data.tex_v, cmd_data.tex_u, cmd_data.pos_z, cmd_data.pos_y,
			cmd_data.pos_x}),
		.raddr (corner),
		.rdata (vtx_rdata)
	);

	assign rd_x    = sum_rdata[SUM_W-1:0];
	assign rd_y    = sum_rdata[2*SUM_W-1:SUM_W];
	assign rd_z    = sum_rdata[3*SUM_W-1:2*SUM_W];
	assign sum_upd = {add_sat(rd_z, t_q[2]), add_sat(rd_y, t_q[1]), add_sat(rd_x, t_q[0])};

	// A load clears the sums; a triangle read-modify-writes one corner at a time
	// so repeated corners accumulate once per occurrence.
	assign sum_we    = vtx_we || (st_q == ST_UPD_WR);
	assign sum_waddr = (st_q == ST_UPD_WR) ? corner : cmd_data.vertex_index;
	assign sum_wdata = (st_q == ST_UPD_WR) ? sum_upd : '0;
	assign sum_raddr = (st_q == ST_RD_ADDR) ? cmd_q.vertex_index : corner;

	vta_ram #(.WIDTH(SUMS_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	vta_serial u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.opa    (opa),
		.opb    (opb),
		.stat   (sstat),
		.result (sres)
	);

	always_comb begin
		mul_a = du1_q;
		mul_b = dv2_q;
		case (idx_q)
			3'd0: begin mul_a = du1_q; mul_b = dv2_q; end
			3'd1: begin mul_a = du2_q; mul_b = dv1_q; end
			3'd2: begin mul_a = dv2_q; mul_b = e1_q[0]; end
			3'd3: begin mul_a = dv1_q; mul_b = e2_q[0]; end
			3'd4: begin mul_a = dv2_q; mul_b = e1_q[1]; end
			3'd5: begin mul_a = dv1_q; mul_b = e2_q[1]; end
			3'd6: begin mul_a = dv2_q; mul_b = e1_q[2]; end
			3'd7: begin mul_a = dv1_q; mul_b = e2_q[2]; end
			default: ;
		endcase
	end

	always_comb begin
		case (idx_q[1:0])
			2'd0:    begin num_k = num_q[0]; mag_k = mag_q[0]; end
			2'd1:    begin num_k = num_q[1]; mag_k = mag_q[1]; end
			default: begin num_k = num_q[2]; mag_k = mag_q[2]; end
		endcase
	end

	assign num_abs = num_k[47] ? (~num_k + 48'd1) : num_k;
	assign det_abs = det_q[47] ? (~det_q + 48'd1) : det_q;

	always_comb begin
		sreq.start = 1'b0;
		sreq.op    = OP_MUL;
		opa        = 64'd0;
		opb        = 49'd0;
		case (st_q)
			ST_MUL_GO: begin
				sreq.start = 1'b1;
				opa = {32'd0, abs32(mul_a)};
				opb = {17'd0, abs32(mul_b)};
			end
			ST_DIV_GO: begin
				sreq.start = 1'b1;
				sreq.op    = OP_DIV;
				opa = {num_abs, 16'd0};
				opb = {1'b0, det_abs};
			end
			ST_SQ_GO: begin
				sreq.start = 1'b1;
				opa = {32'd0, mag_k[31:0]};
				opb = {17'd0, mag_k[31:0]};
			end
			ST_SQRT_GO: begin
				sreq.start = 1'b1;
				sreq.op    = OP_SQRT;
				opa = ssum_q;
			end
			ST_Q_GO: begin
				sreq.start = 1'b1;
				sreq.op    = OP_DIV;
				opa = {18'd0, mag_k[30:0], 15'd0};
				opb = {17'd0, len_q};
			end
			default: ;
		endcase
	end

	// Signed product shifted right 16 rounds toward minus infinity.
	assign sprod  = mneg_q ? (~sres + 64'd1) : sres;
	assign prod_s = sprod[63:16];
	assign diff   = prod_q - prod_s;
	assign quo    = sres[40:0];

	always_comb begin
		if (!dneg_q)
			tsat = (sstat.ovf || quo[40] || quo[39]) ? 40'h7f_ffff_ffff : quo[39:0];
		else if (sstat.ovf || quo[40] || (quo[39] && (|quo[38:0])))
			tsat = 40'h80_0000_0000;
		else
			tsat = ~quo[39:0] + 40'd1;
	end

	always_comb begin
		if (!sgn_q[idx_q[1:0]])
			qsat = (sstat.ovf || (|quo[40:15])) ? 16'h7fff : quo[15:0];
		else if (sstat.ovf || (|quo[40:16]) || (quo[15] && (|quo[14:0])))
			qsat = 16'h8000;
		else
			qsat = ~quo[15:0] + 16'd1;
	end

	assign big = (|mag_q[0][39:31]) || (|mag_q[1][39:31]) || (|mag_q[2][39:31]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			idx_q       <= 3'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && out_free) res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					idx_q <= 3'd0;
					if (accept) begin
						case (cmd_data.command)
							CMD_TRI:  st_q <= ST_FETCH;
							CMD_READ: st_q <= ST_RD_ADDR;
							default:  st_q <= ST_IDLE;
						endcase
					end
				end
				ST_FETCH: begin
					if (idx_q == 3'd3) begin
						st_q  <= ST_MUL_GO;
						idx_q <= 3'd0;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_MUL_GO: st_q <= ST_MUL_WAIT;
				ST_MUL_WAIT: begin
					if (sstat.done) begin
						if (idx_q == 3'd1 && diff == 48'd0) begin
							st_q <= ST_IDLE;
						end else if (idx_q == 3'd7) begin
							st_q  <= ST_DIV_GO;
							idx_q <= 3'd0;
						end else begin
							st_q  <= ST_MUL_GO;
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_DIV_GO: st_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (sstat.done) begin
						if (idx_q == 3'd2) begin
							st_q  <= ST_UPD_RD;
							idx_q <= 3'd0;
						end else begin
							st_q  <= ST_DIV_GO;
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_UPD_RD: st_q <= ST_UPD_WR;
				ST_UPD_WR: begin
					if (idx_q == 3'd2) begin
						st_q <= ST_IDLE;
					end else begin
						st_q  <= ST_UPD_RD;
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_RD_ADDR: st_q <= ST_RD_CAP;
				ST_RD_CAP: begin
					if (sum_rdata == '0) st_q <= ST_OUT;
					else                 st_q <= ST_RD_SHIFT;
				end
				ST_RD_SHIFT: begin
					if (!big) begin
						st_q  <= ST_SQ_GO;
						idx_q <= 3'd0;
					end
				end
				ST_SQ_GO: st_q <= ST_SQ_WAIT;
				ST_SQ_WAIT: begin
					if (sstat.done) begin
						if (idx_q == 3'd2) begin
							st_q <= ST_SQRT_GO;
						end else begin
							st_q  <= ST_SQ_GO;
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_SQRT_GO: st_q <= ST_SQRT_WAIT;
				ST_SQRT_WAIT: begin
					if (sstat.done) begin
						idx_q <= 3'd0;
						if (sres[31:0] == 32'd0) st_q <= ST_OUT;
						else                     st_q <= ST_Q_GO;
					end
				end
				ST_Q_GO: st_q <= ST_Q_WAIT;
				ST_Q_WAIT: begin
					if (sstat.done) begin
						if (idx_q == 3'd2) begin
							st_q <= ST_OUT;
						end else begin
							st_q  <= ST_Q_GO;
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_OUT: begin
					if (out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cmd_q <= cmd_data;
		case (st_q)
			ST_FETCH: begin
				if (idx_q == 3'd1) v0_q <= vtx_rdata;
				if (idx_q == 3'd2) begin
					e1_q[0] <= sub_sat(vtx_rdata[31:0], v0_q[31:0]);
					e1_q[1] <= sub_sat(vtx_rdata[63:32], v0_q[63:32]);
					e1_q[2] <= sub_sat(vtx_rdata[95:64], v0_q[95:64]);
					du1_q   <= sub_sat(vtx_rdata[127:96], v0_q[127:96]);
					dv1_q   <= sub_sat(vtx_rdata[159:128], v0_q[159:128]);
				end
				if (idx_q == 3'd3) begin
					e2_q[0] <= sub_sat(vtx_rdata[31:0], v0_q[31:0]);
					e2_q[1] <= sub_sat(vtx_rdata[63:32], v0_q[63:32]);
					e2_q[2] <= sub_sat(vtx_rdata[95:64], v0_q[95:64]);
					du2_q   <= sub_sat(vtx_rdata[127:96], v0_q[127:96]);
					dv2_q   <= sub_sat(vtx_rdata[159:128], v0_q[159:128]);
				end
			end
			ST_MUL_GO: mneg_q <= mul_a[31] ^ mul_b[31];
			ST_MUL_WAIT: begin
				if (sstat.done) begin
					if (!idx_q[0]) begin
						prod_q <= prod_s;
					end else begin
						case (idx_q[2:1])
							2'd0:    det_q    <= diff;
							2'd1:    num_q[0] <= diff;
							2'd2:    num_q[1] <= diff;
							default: num_q[2] <= diff;
						endcase
					end
				end
			end
			ST_DIV_GO: dneg_q <= num_k[47] ^ det_q[47];
			ST_DIV_WAIT: begin
				if (sstat.done) begin
					case (idx_q[1:0])
						2'd0:    t_q[0] <= tsat;
						2'd1:    t_q[1] <= tsat;
						default: t_q[2] <= tsat;
					endcase
				end
			end
			ST_RD_CAP: begin
				mag_q[0] <= rd_x[39] ? (~rd_x + 40'd1) : rd_x;
				mag_q[1] <= rd_y[39] ? (~rd_y + 40'd1) : rd_y;
				mag_q[2] <= rd_z[39] ? (~rd_z + 40'd1) : rd_z;
				sgn_q[0] <= rd_x[39];
				sgn_q[1] <= rd_y[39];
				sgn_q[2] <= rd_z[39];
				zero_q   <= (sum_rdata == '0);
				rq_q[0]  <= 16'd0;
				rq_q[1]  <= 16'd0;
				rq_q[2]  <= 16'd0;
				ssum_q   <= 64'd0;
			end
			ST_RD_SHIFT: begin
				// All three shift together until each fits in 31 bits.
				if (big) begin
					mag_q[0] <= {1'b0, mag_q[0][39:1]};
					mag_q[1] <= {1'b0, mag_q[1][39:1]};
					mag_q[2] <= {1'b0, mag_q[2][39:1]};
				end
			end
			ST_SQ_WAIT: if (sstat.done) ssum_q <= ssum_q + sres;
			ST_SQRT_WAIT: begin
				if (sstat.done) begin
					len_q <= sres[31:0];
					if (sres[31:0] == 32'd0) zero_q <= 1'b1;
				end
			end
			ST_Q_WAIT: begin
				if (sstat.done) begin
					case (idx_q[1:0])
						2'd0:    rq_q[0] <= qsat;
						2'd1:    rq_q[1] <= qsat;
						default: rq_q[2] <= qsat;
					endcase
				end
			end
			ST_OUT: begin
				if (out_free) begin
					res_q.out_vertex  <= cmd_q.vertex_index;
					res_q.tangent_x   <= rq_q[0];
					res_q.tangent_y   <= rq_q[1];
					res_q.tangent_z   <= rq_q[2];
					res_q.zero_length <= zero_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/vta_checker.sv
// Port-level checks of the vertex tangent accumulator, bound to the top level.
// Uses vta_pkg.
`default_nettype none

module vta_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input vta_pkg::vta_cmd_t cmd_data,
	input logic              res_valid,
	input logic              res_stall,
	input vta_pkg::vta_res_t res_data
);
	import vta_pkg::*;

	// A stalled result beat holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result beat changed while stalled");

	// A zero-length result carries a zero vector.
	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.zero_length |->
		res_data.tangent_x == 16'sd0 && res_data.tangent_y == 16'sd0 &&
		res_data.tangent_z == 16'sd0)
		else $error("zero_length result with nonzero tangent");

	// A normalized vector never comes out all zero.
	a_unit_vec: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.zero_length |->
		res_data.tangent_x != 16'sd0 || res_data.tangent_y != 16'sd0 ||
		res_data.tangent_z != 16'sd0)
		else $error("normalized tangent is all zero");

	// A load is finished in the cycle it is taken.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd_data.command == CMD_LOAD |=> !cmd_stall)
		else $error("block busy after a load");

	// A read keeps the block busy while the vector is normalized.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd_data.command == CMD_READ |=> cmd_stall)
		else $error("block idle right after a read");

endmodule

bind vertex_tangent_accumulator vta_checker u_vta_checker (.*);

`default_nettype wire
